FILE: rtl/tcpu_pkg.sv
`default_nettype none
package tcpu_pkg;

  localparam int MemWords = 32768;
  localparam int MemAw    = $clog2(MemWords);
  localparam int StackBase  = 4096;
  localparam int StackLimit = 12 * 1024;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_START = 2'd2,
    MODE_EXEC  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_PUSH = 4'd5, OP_POP = 4'd6, OP_MOV = 4'd7,
    OP_LOAD = 4'd8, OP_STORE = 4'd9, OP_JMP = 4'd10, OP_JNZ = 4'd11,
    OP_JZ = 4'd12, OP_JN = 4'd13, OP_CALL = 4'd14, OP_RET = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_OVER = 3'd1, FLT_UNDER = 3'd2, FLT_SPPOP = 3'd3,
    FLT_DIV0 = 3'd4
  } fault_e;

  localparam logic [0:0] CfgStartPc = 1'b0;
  localparam logic [0:0] CfgEndPc   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MEMRD, ST_FETCH, ST_DECODE, ST_MEMWAIT,
    ST_DIVIDE, ST_DIVFIN, ST_RDATA, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // write zero at clear counter
    logic cap_in;      // capture input transaction
    logic do_wr;       // mode 0 write
    logic rd_issue;    // mode 1 read address
    logic rd_cap;      // capture read word
    logic start;       // mode 2
    logic fetch;       // issue fetch at pc
    logic decode;      // ir is ready; execute, or start an op that finishes in a later state
    logic mem_fin;     // finish load/pop/ret/mul
    logic div_step;
    logic div_fin;
    logic clr_rd;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic can_exec;
    logic need_mem;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/tcpu_datapath.sv
`default_nettype none
module tcpu_datapath
  import tcpu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctl_t        ctl_i,
  output sts_t             sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [14:0] address_i,
  input  wire logic [15:0] data_i,
  output logic [15:0]      rf0_o,
  output logic [15:0]      rf1_o,
  output logic [15:0]      rf2_o,
  output logic [15:0]      rf3_o,
  output logic [15:0]      rf4_o,
  output logic [15:0]      rf5_o,
  output logic [15:0]      pc_o,
  output logic [2:0]       fault_o,
  output logic             halted_o,
  output logic [15:0]      rdata_o,
  output logic [1:0]       mode_o,
  output logic [3:0]       op_o
);

  logic [15:0] mem [MemWords];
  logic [15:0] mem_rd_q;
  logic [MemAw-1:0] clr_q;
  logic [15:0] rf_q [8];
  logic [15:0] pc_q;
  logic [2:0]  fault_q;
  logic [11:0] start_q, end_q;
  logic [1:0]  mode_q;
  logic [14:0] addr_q;
  logic [15:0] data_q, rdata_q, ir_q;

  // divider state
  logic [15:0] dq_q, rem_q, dvs_q;
  logic [4:0]  dcnt_q;
  logic        nq_q, nr_q;

  // multiplier product, one stage after decode
  logic [15:0] prod_q;
  logic [31:0] prod;

  function automatic logic [MemAw-1:0] midx(input logic [15:0] a);
    return a[MemAw-1:0];
  endfunction

  // decode fields
  op_e         op;
  logic [2:0]  dst;
  logic [15:0] rdst, rsrc, s8, s11, sp, cx;
  logic signed [15:0] sps;
  assign op   = op_e'(ir_q[15:12]);
  assign dst  = ir_q[2:0];
  assign rdst = rf_q[dst];
  assign rsrc = rf_q[ir_q[5:3]];
  assign s8   = ir_q[11] ? rsrc : {8'd0, ir_q[10:3]};
  assign s11  = ir_q[11] ? rsrc : {5'd0, ir_q[10:0]};
  assign sp   = rf_q[3];
  assign sps  = sp;
  assign cx   = rf_q[2];

  logic ovf, unf;
  assign ovf = sps >= 16'(StackLimit);
  assign unf = sps <= 16'(StackBase);

  assign sts_o.clr_done = (clr_q == MemAw'(MemWords - 1));
  assign sts_o.can_exec = (pc_q < {4'd0, end_q}) && (fault_q == FLT_NONE);
  assign sts_o.need_mem = (op == OP_LOAD) || (op == OP_POP && dst != 3'd3 && !unf) ||
                          (op == OP_RET && !unf);
  assign sts_o.need_div = (op == OP_DIV) && (s8 != 16'd0);
  assign sts_o.div_done = (dcnt_q == 5'd0);

  // memory address select
  logic [MemAw-1:0] raddr, waddr;
  logic [15:0]      wdata;
  logic             we;
  logic [15:0]      spm1;
  assign spm1 = sp - 16'd1;
  always_comb begin
    raddr = midx(pc_q);
    we    = 1'b0;
    waddr = midx(sp);
    wdata = 16'd0;
    if (ctl_i.clr_step) begin
      we = 1'b1; waddr = clr_q;
    end else if (ctl_i.do_wr) begin
      we = 1'b1; waddr = midx({1'b0, addr_q}); wdata = data_q;
    end else if (ctl_i.decode) begin
      case (op)
        OP_PUSH: begin we = !ovf; waddr = midx(sp); wdata = s11; end
        OP_CALL: begin we = !ovf; waddr = midx(sp); wdata = pc_q; end
        OP_STORE: begin we = 1'b1; waddr = midx(rf_q[5]); wdata = s11; end
        default: we = 1'b0;
      endcase
    end
    if (ctl_i.rd_issue) raddr = midx({1'b0, addr_q});
    else if (ctl_i.decode) raddr = (op == OP_LOAD) ? midx(rf_q[5]) : midx(spm1);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    mem_rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_in) begin
      mode_q <= mode_i; addr_q <= address_i; data_q <= data_i;
    end
    if (ctl_i.fetch) ir_q <= mem_rd_q;
  end

  // signed divide, one quotient bit per cycle on magnitudes
  logic [16:0] trial;
  logic [15:0] amag, bmag;
  assign amag  = rdst[15] ? -rdst : rdst;
  assign bmag  = s8[15] ? -s8 : s8;
  assign trial = {rem_q, dq_q[15]} - {1'b0, dvs_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (ctl_i.decode && sts_o.need_div && sts_o.can_exec) begin
      dcnt_q <= 5'd16;
    end else if (ctl_i.div_step && dcnt_q != 5'd0) begin
      dcnt_q <= dcnt_q - 5'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.decode) begin
      dq_q <= amag; rem_q <= '0; dvs_q <= bmag;
      nq_q <= rdst[15] ^ s8[15]; nr_q <= rdst[15];
    end else if (ctl_i.div_step && dcnt_q != 5'd0) begin
      if (!trial[16]) begin
        rem_q <= trial[15:0]; dq_q <= {dq_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], dq_q[15]}; dq_q <= {dq_q[14:0], 1'b0};
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
      rf_q[3] <= 16'(StackBase);
      pc_q <= 16'd1; fault_q <= FLT_NONE;
      start_q <= 12'd1; end_q <= 12'd4095; rdata_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStartPc) start_q <= cfg_data_i;
        else end_q <= cfg_data_i;
      end
      if (ctl_i.clr_rd) rdata_q <= '0;
      if (ctl_i.rd_cap) rdata_q <= mem_rd_q;
      if (ctl_i.start) begin
        pc_q <= {4'd0, start_q}; fault_q <= FLT_NONE;
      end
      if (ctl_i.decode) begin
        case (op)
          OP_ADD: begin rf_q[dst] <= rdst + s8; pc_q <= pc_q + 16'd1; end
          OP_SUB: begin rf_q[dst] <= rdst - s8; pc_q <= pc_q + 16'd1; end
          OP_MOV: begin rf_q[dst] <= s8; pc_q <= pc_q + 16'd1; end
          OP_DIV: if (s8 == 16'd0) fault_q <= FLT_DIV0;
          OP_PUSH, OP_CALL: begin
            if (ovf) fault_q <= FLT_OVER;
            else begin
              rf_q[3] <= sp + 16'd1;
              pc_q <= (op == OP_CALL) ? {4'd0, ir_q[11:0]} : pc_q + 16'd1;
            end
          end
          OP_POP: begin
            if (dst == 3'd3) fault_q <= FLT_SPPOP;
            else if (unf) fault_q <= FLT_UNDER;
            else rf_q[3] <= spm1;
          end
          OP_RET: begin
            if (unf) fault_q <= FLT_UNDER;
            else rf_q[3] <= spm1;
          end
          OP_LOAD, OP_MUL: ;
          OP_JMP: pc_q <= {4'd0, ir_q[11:0]};
          OP_JNZ: pc_q <= (cx != 16'd0) ? {4'd0, ir_q[11:0]} : pc_q + 16'd1;
          OP_JZ:  pc_q <= (cx == 16'd0) ? {4'd0, ir_q[11:0]} : pc_q + 16'd1;
          OP_JN:  pc_q <= cx[15] ? {4'd0, ir_q[11:0]} : pc_q + 16'd1;
          default: pc_q <= pc_q + 16'd1;
        endcase
      end
      if (ctl_i.mem_fin) begin
        // multiply is finished here too, keeping the product a stage away
        if (op == OP_RET) pc_q <= mem_rd_q + 16'd1;
        else if (op == OP_MUL) begin
          rf_q[dst] <= prod_q; pc_q <= pc_q + 16'd1;
        end else begin
          rf_q[dst] <= mem_rd_q; pc_q <= pc_q + 16'd1;
        end
      end
      if (ctl_i.div_fin) begin
        // remainder wins when the destination is cx
        if (dst != 3'd2) rf_q[dst] <= nq_q ? -dq_q : dq_q;
        rf_q[2]   <= nr_q ? -rem_q : rem_q;
        pc_q <= pc_q + 16'd1;
      end
    end
  end

  assign prod = rdst * s8;
  always_ff @(posedge clk_i) begin
    if (ctl_i.decode) prod_q <= prod[15:0];
  end

  assign rf0_o = rf_q[0];
  assign rf1_o = rf_q[1];
  assign rf2_o = rf_q[2];
  assign rf3_o = rf_q[3];
  assign rf4_o = rf_q[4];
  assign rf5_o = rf_q[5];
  assign pc_o  = pc_q;
  assign fault_o = fault_q;
  assign halted_o = (pc_q >= {4'd0, end_q}) || (fault_q != FLT_NONE);
  assign rdata_o = rdata_q;
  assign mode_o = mode_q;
  assign op_o = ir_q[15:12];

endmodule
`default_nettype wire

FILE: rtl/tcpu_ctrl.sv
`default_nettype none
module tcpu_ctrl
  import tcpu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] mode_i,
  input  wire logic [3:0] op_i,
  input  wire sts_t       sts_i,
  output ctl_t            ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl_o.cap_in = 1'b1;
          state_d = ST_MEMRD;
        end
      end
      ST_MEMRD: begin
        case (mode_e'(mode_i))
          MODE_WRITE: begin ctl_o.do_wr = 1'b1; ctl_o.clr_rd = 1'b1; state_d = ST_OUT; end
          MODE_READ:  begin ctl_o.rd_issue = 1'b1; state_d = ST_RDATA; end
          MODE_START: begin ctl_o.start = 1'b1; ctl_o.clr_rd = 1'b1; state_d = ST_OUT; end
          default: begin
            ctl_o.clr_rd = 1'b1;
            state_d = sts_i.can_exec ? ST_FETCH : ST_OUT;
          end
        endcase
      end
      ST_RDATA: begin ctl_o.rd_cap = 1'b1; state_d = ST_OUT; end
      ST_FETCH: begin ctl_o.fetch = 1'b1; state_d = ST_DECODE; end
      ST_DECODE: begin
        ctl_o.decode = 1'b1;
        if (sts_i.need_div) state_d = ST_DIVIDE;
        else if (sts_i.need_mem || op_i == OP_MUL) state_d = ST_MEMWAIT;
        else state_d = ST_OUT;
      end
      ST_MEMWAIT: begin ctl_o.mem_fin = 1'b1; state_d = ST_OUT; end
      ST_DIVIDE: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_DIVFIN;
      end
      ST_DIVFIN: begin ctl_o.div_fin = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/teaching_cpu_16bit_step.sv
`default_nettype none
// channel | handshake             | payload
// cfg     | cfg_we_i              | cfg_idx_i, cfg_data_i
// in      | in_valid / in_stall   | mode_i, address_i, data_i
// out     | out_valid / out_stall | reg_*_o, prog_counter_o, fault_code_o, halted_o, read_data_o
// After reset a sweep clears all 32768 memory words; no transaction is taken then.
// Write/start and an execute while halted pass through to the output state; a read adds a
// read-data state; an execute adds fetch and decode (load, pop, ret and mult also a memory-wait
// state), and a divide also a divide loop and a finish state (one quotient bit per cycle).
// One command at a time; the result holds in the output while out_stall is high.
module teaching_cpu_16bit_step
  import tcpu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode_i,
  input  wire logic [14:0] address_i,
  input  wire logic [15:0] data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] reg_ax_o,
  output logic signed [15:0] reg_bx_o,
  output logic signed [15:0] reg_cx_o,
  output logic signed [15:0] reg_sp_o,
  output logic signed [15:0] reg_bp_o,
  output logic signed [15:0] reg_ma_o,
  output logic [15:0]      prog_counter_o,
  output logic [2:0]       fault_code_o,
  output logic             halted_o,
  output logic [15:0]      read_data_o
);

  ctl_t ctl;
  sts_t sts;
  logic [1:0] mode_q;
  logic [3:0] op;
  logic [15:0] r0, r1, r2, r3, r4, r5;

  tcpu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .mode_i(mode_q), .op_i(op), .sts_i(sts), .ctl_o(ctl)
  );

  tcpu_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i, .address_i, .data_i,
    .rf0_o(r0), .rf1_o(r1), .rf2_o(r2), .rf3_o(r3), .rf4_o(r4), .rf5_o(r5),
    .pc_o(prog_counter_o), .fault_o(fault_code_o), .halted_o,
    .rdata_o(read_data_o), .mode_o(mode_q), .op_o(op)
  );

  assign reg_ax_o = r0;
  assign reg_bx_o = r1;
  assign reg_cx_o = r2;
  assign reg_sp_o = r3;
  assign reg_bp_o = r4;
  assign reg_ma_o = r5;

endmodule
`default_nettype wire
